FILE: rtl/slt_pkg.sv
package slt_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;
  localparam logic [1:0] ACT_DELETE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [4:0]         found_index;
    logic [2:0]         status;
    logic [5:0]         entry_count;
    logic               is_empty;
  } slt_result_t;

endpackage

FILE: rtl/slt_ram.sv
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/slt_engine.sv
module slt_engine import slt_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         action_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic               hold_i,
  output logic               busy_o,
  output logic               done_o,
  output slt_result_t        res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_INSW = 3'd4;
  localparam logic [2:0] S_DELR = 3'd5;
  localparam logic [2:0] S_DEL  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         pa_q, pa_d;
  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic [WORD_WIDTH-1:0] res_q, res_d;
  logic [AW-1:0]         found_q, found_d;
  logic [2:0]            status_q, status_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [PW-1:0]         pos_w, cnt_w;
  logic                  pos_bad_rd;

  assign pos_w      = PW'(position_i);
  assign cnt_w      = PW'(count_q);
  assign pos_bad_rd = (pos_w == '0) || (pos_w > cnt_w);

  slt_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pa_d      = pa_q;
    word_d    = word_q;
    res_d     = res_q;
    found_d   = found_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d    = '0;
          found_d  = '0;
          status_d = ST_OK;
          word_d   = WORD_WIDTH'(value_i);
          pa_d     = AW'(pos_w - 1'b1);
          case (action_i)
            ACT_READ, ACT_DELETE: begin
              if (cnt_w == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (pos_bad_rd) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(pos_w - 1'b1);
                state_d   = (action_i == ACT_READ) ? S_READ : S_DELR;
              end
            end
            ACT_FIND: begin
              if (cnt_w == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ptr_d     = '0;
                state_d   = S_FIND;
              end
            end
            default: begin
              if (cnt_w >= PW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if ((pos_w == '0) || (pos_w > cnt_w + 1'b1)) begin
                status_d = ST_BADPOS;
                state_d  = S_DONE;
              end else if (pos_w == cnt_w + 1'b1) begin
                state_d = S_INSW;
              end else begin
                // shift walks down from the top entry
                ram_re    = 1'b1;
                ram_raddr = AW'(cnt_w - 1'b1);
                ptr_d     = count_q;
                state_d   = S_INS;
              end
            end
          endcase
        end
      end
      S_READ: begin
        res_d   = ram_rdata;
        state_d = S_DONE;
      end
      S_FIND: begin
        if (ram_rdata == word_q) begin
          found_d = AW'(ptr_q);
          state_d = S_DONE;
        end else if (CW'(ptr_q + 1'b1) == count_q) begin
          status_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_q + 1'b1);
          ptr_d     = CW'(ptr_q + 1'b1);
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_q);
        if (ptr_q == CW'(CW'(pa_q) + 1'b1)) begin
          state_d = S_INSW;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_q - 2'd2);
          ptr_d     = CW'(ptr_q - 1'b1);
        end
      end
      S_INSW: begin
        ram_we    = 1'b1;
        ram_waddr = pa_q;
        ram_wdata = word_q;
        count_d   = CW'(count_q + 1'b1);
        state_d   = S_DONE;
      end
      S_DELR: begin
        res_d = ram_rdata;
        if (CW'(CW'(pa_q) + 1'b1) == count_q) begin
          count_d = CW'(count_q - 1'b1);
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pa_q + 1'b1);
          ptr_d     = CW'(CW'(pa_q) + 1'b1);
          state_d   = S_DEL;
        end
      end
      S_DEL: begin
        // move entry ptr down one place while fetching the next one
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_q - 1'b1);
        if (CW'(ptr_q + 1'b1) == count_q) begin
          count_d = CW'(count_q - 1'b1);
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_q + 1'b1);
          ptr_d     = CW'(ptr_q + 1'b1);
        end
      end
      S_DONE: begin
        if (!hold_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    pa_q     <= pa_d;
    word_q   <= word_d;
    res_q    <= res_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  assign res_o.result_value = 32'($signed(res_q));
  assign res_o.found_index  = 5'(found_q);
  assign res_o.status       = status_q;
  assign res_o.entry_count  = 6'(count_q);
  assign res_o.is_empty     = (count_q == '0);

endmodule

FILE: rtl/sequential_list_table.sv
// Bounded ordered list of signed words kept in one synchronous memory with a
// live entry count. Each beat runs one operation: read at a 1-based position,
// find the first 0-based index holding a value, insert at a 1-based position
// (later entries move up) or delete at a 1-based position (later entries move
// down, the removed word comes back). Every beat gives exactly one result beat
// with status, count after the operation and an empty flag. A rejected
// operation (empty, full, bad position) touches no memory; read fetches one
// entry; find reads from index 0 up to a match or the last entry; insert and
// delete move the later entries one place each. The memory's single read port
// walks the list one entry a cycle while the write port stores moved entries.
// One operation runs at a time; the next beat is taken once the result sits in
// the output register, even while that result is still stalled.
module sequential_list_table import slt_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [4:0]         found_index_o,
  output logic [2:0]         status_o,
  output logic [5:0]         entry_count_o,
  output logic               is_empty_o
);

  logic        busy, done, out_busy, out_load, start;
  slt_result_t eng_res;
  slt_result_t out_res_q;
  logic        out_valid_q, out_valid_d;

  assign start    = in_valid_i && !busy;
  assign out_busy = out_valid_q && out_stall_i;
  assign out_load = done && !out_busy;

  slt_engine #(
    .DEPTH(DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .hold_i     (out_busy),
    .busy_o     (busy),
    .done_o     (done),
    .res_o      (eng_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= eng_res;
    end
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q.result_value;
  assign found_index_o  = out_res_q.found_index;
  assign status_o       = out_res_q.status;
  assign entry_count_o  = out_res_q.entry_count;
  assign is_empty_o     = out_res_q.is_empty;

endmodule

FILE: rtl/slt_checker.sv
module slt_checker import slt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] result_value_o,
  input logic [4:0]         found_index_o,
  input logic [2:0]         status_o,
  input logic [5:0]         entry_count_o,
  input logic               is_empty_o
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o)
      && $stable(status_o) && $stable(entry_count_o))
    else $error("stalled result beat changed");

  // one operation at a time: an accepted beat keeps the input stalled next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == 6'd0)))
    else $error("empty flag disagrees with count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (result_value_o == 32'sd0)
      && (found_index_o == 5'd0))
    else $error("failed operation returned data");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (entry_count_o == 6'(DEPTH)))
    else $error("full status with list not full");

endmodule

bind sequential_list_table slt_checker #(.DEPTH(DEPTH)) u_slt_checker (.*);
